// ----- rtl/rbr_pkg.sv -----
package rbr_pkg;

    // Default sizes of the tables.
    localparam int ROB_DEPTH_DEF  = 16;
    localparam int RRF_DEPTH_DEF  = 16;
    localparam int ARF_DEPTH_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes.
    localparam logic [2:0] OP_ROB_WR  = 3'd0;
    localparam logic [2:0] OP_RRF_WR  = 3'd1;
    localparam logic [2:0] OP_ARF_MAP = 3'd2;
    localparam logic [2:0] OP_COMMIT  = 3'd3;
    localparam logic [2:0] OP_ARF_RD  = 3'd4;

    // One request as presented on the command port.
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  rob_index;
        logic [3:0]  ren_tag;
        logic        has_rename;
        logic        flag_busy;
        logic        flag_finished;
        logic        flag_valid;
        logic [3:0]  rrf_index;
        logic [4:0]  dest_reg;
        logic [31:0] data_value;
        logic        execute_finished;
    } req_t;

    // One result as presented on the result port.
    typedef struct packed {
        logic [4:0]  retired_count;
        logic        stage_done;
        logic        buffer_was_empty;
        logic [31:0] read_data;
        logic        read_busy;
        logic [3:0]  head_index;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic table_write;
        logic finish;
        logic retire;
        logic rename_update;
        logic arf_read;
        logic read_out;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       complete_done;
        logic       execute_finished;
        logic       head_ok;
        logic       head_renamed;
    } dp_status_t;

endpackage

// ----- rtl/reorder_buffer_retire_top.sv -----
// Retire stage with a 16-entry reorder buffer, a rename file and an architectural
// register file. A request is taken when start is high and busy is low; its one
// result appears on rsp for exactly one cycle with done high, and there is no way
// to hold it off, so the receiver must capture it in that cycle. done is the
// registered emit, given in the execute state for table writes, unused codes and
// commits that finish the stage or find it finished, in the read state for reads,
// and in the check state for other commits once the head entry is not ready. A
// commit walks the buffer from the head one entry at a time: an entry with a
// rename tag passes through the rename state after the check state, since the
// rename file is a memory read once per entry and its data then written to the
// architectural file. busy stays high until the result is on its way; a new
// request can be taken in the cycle done shows.
module reorder_buffer_retire_top
#(
    parameter int ROB_DEPTH  = rbr_pkg::ROB_DEPTH_DEF,
    parameter int RRF_DEPTH  = rbr_pkg::RRF_DEPTH_DEF,
    parameter int ARF_DEPTH  = rbr_pkg::ARF_DEPTH_DEF,
    parameter int DATA_WIDTH = rbr_pkg::DATA_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rbr_pkg::req_t req,
    output logic          done,
    output rbr_pkg::rsp_t rsp
);

    rbr_pkg::ctl_cmd_t   cmd;
    rbr_pkg::dp_status_t status;

    // Sequencer.
    rbr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Tables, head pointer and result register.
    rbr_datapath
    #(
        .ROB_DEPTH  (ROB_DEPTH),
        .RRF_DEPTH  (RRF_DEPTH),
        .ARF_DEPTH  (ARF_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .rsp    (rsp)
    );

endmodule

// ----- rtl/rbr_ctrl.sv -----
module rbr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rbr_pkg::dp_status_t status,
    output rbr_pkg::ctl_cmd_t   cmd,
    output logic                busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_RENAME = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.op)
                    rbr_pkg::OP_COMMIT:
                    begin
                        if (status.complete_done)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (status.execute_finished)
                        begin
                            cmd.finish = 1'b1;
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    rbr_pkg::OP_ARF_RD:
                    begin
                        cmd.arf_read = 1'b1;
                        state_next   = ST_READ;
                    end
                    default:
                    begin
                        // Table writes act here; unused codes change nothing.
                        cmd.table_write = 1'b1;
                        cmd.emit        = 1'b1;
                        state_next      = ST_IDLE;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (status.head_ok)
                begin
                    cmd.retire = 1'b1;
                    if (status.head_renamed)
                    begin
                        state_next = ST_RENAME;
                    end
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RENAME:
            begin
                cmd.rename_update = 1'b1;
                state_next        = ST_CHECK;
            end
            ST_READ:
            begin
                cmd.read_out = 1'b1;
                cmd.emit     = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rbr_datapath.sv -----
module rbr_datapath
#(
    parameter int ROB_DEPTH  = rbr_pkg::ROB_DEPTH_DEF,
    parameter int RRF_DEPTH  = rbr_pkg::RRF_DEPTH_DEF,
    parameter int ARF_DEPTH  = rbr_pkg::ARF_DEPTH_DEF,
    parameter int DATA_WIDTH = rbr_pkg::DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rbr_pkg::req_t       req,
    input  rbr_pkg::ctl_cmd_t   cmd,
    output rbr_pkg::dp_status_t status,
    output logic                done,
    output rbr_pkg::rsp_t       rsp
);

    localparam int ROB_AW = $clog2(ROB_DEPTH);
    localparam int RRF_AW = $clog2(RRF_DEPTH);
    localparam int ARF_AW = $clog2(ARF_DEPTH);
    localparam int CNT_W  = $clog2(ROB_DEPTH + 1);

    // Latched request.
    rbr_pkg::req_t req_reg;

    // Reorder buffer, held in flip-flops.
    logic [ROB_DEPTH-1:0] rob_busy_reg;
    logic [ROB_DEPTH-1:0] rob_finished_reg;
    logic [ROB_DEPTH-1:0] rob_valid_reg;
    logic [4:0]           rob_tag_reg [ROB_DEPTH];
    logic [ROB_AW-1:0]    head_reg;
    logic                 complete_done_reg;

    // Rename file: data and destination in a memory.
    logic [DATA_WIDTH-1:0] rrf_data_mem [RRF_DEPTH];
    logic [4:0]            rrf_dest_mem [RRF_DEPTH];
    logic [DATA_WIDTH-1:0] rrf_data_q_reg;
    logic [4:0]            rrf_dest_q_reg;
    logic [3:0]            ret_tag_reg;

    // Architectural file: data in a memory with valid bits, tags and busy in flops.
    logic [DATA_WIDTH-1:0] arf_data_mem [ARF_DEPTH];
    logic [ARF_DEPTH-1:0]  arf_valid_reg;
    logic [3:0]            arf_tag_reg [ARF_DEPTH];
    logic [ARF_DEPTH-1:0]  arf_busy_reg;
    logic [DATA_WIDTH-1:0] arf_rd_q_reg;
    logic                  arf_rd_valid_reg;
    logic                  arf_rd_busy_reg;

    // Result register and strobe.
    logic [CNT_W-1:0]      count_reg;
    rbr_pkg::rsp_t         rsp_reg;
    logic                  done_reg;

    // Decoded addresses and range checks.
    logic                  rob_in_range;
    logic                  rrf_in_range;
    logic                  dest_in_range;
    logic [ROB_AW-1:0]     rob_addr;
    logic [RRF_AW-1:0]     rrf_addr;
    logic [ARF_AW-1:0]     dest_addr;
    logic [4:0]            head_tag;
    logic                  head_tag_ok;
    logic [RRF_AW-1:0]     head_rrf_addr;
    logic                  ren_dest_ok;
    logic [ARF_AW-1:0]     ren_dest_addr;
    logic [ROB_AW-1:0]     head_inc;

    assign rob_in_range  = (32'(req_reg.rob_index) < ROB_DEPTH);
    assign rrf_in_range  = (32'(req_reg.rrf_index) < RRF_DEPTH);
    assign dest_in_range = (32'(req_reg.dest_reg) < ARF_DEPTH);
    assign rob_addr      = ROB_AW'(req_reg.rob_index);
    assign rrf_addr      = RRF_AW'(req_reg.rrf_index);
    assign dest_addr     = ARF_AW'(req_reg.dest_reg);

    assign head_tag      = rob_tag_reg[head_reg];
    assign head_tag_ok   = head_tag[4] && (32'(head_tag[3:0]) < RRF_DEPTH);
    assign head_rrf_addr = RRF_AW'(head_tag[3:0]);
    assign ren_dest_ok   = (32'(rrf_dest_q_reg) < ARF_DEPTH);
    assign ren_dest_addr = ARF_AW'(rrf_dest_q_reg);
    assign head_inc      = (32'(head_reg) == ROB_DEPTH - 1) ? '0 : head_reg + 1'b1;

    // Status towards the controller.
    always_comb
    begin
        status.op               = req_reg.op;
        status.complete_done    = complete_done_reg;
        status.execute_finished = req_reg.execute_finished;
        status.head_ok          = rob_busy_reg[head_reg] & rob_finished_reg[head_reg]
                                  & rob_valid_reg[head_reg];
        status.head_renamed     = head_tag_ok;
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    // Reorder buffer entries, head pointer and stage state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rob_busy_reg      <= '0;
            rob_finished_reg  <= '0;
            rob_valid_reg     <= '0;
            for (int i = 0; i < ROB_DEPTH; i++)
            begin
                rob_tag_reg[i] <= '0;
            end
            head_reg          <= '0;
            complete_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.table_write && (req_reg.op == rbr_pkg::OP_ROB_WR) && rob_in_range)
            begin
                rob_busy_reg[rob_addr]     <= req_reg.flag_busy;
                rob_finished_reg[rob_addr] <= req_reg.flag_finished;
                rob_valid_reg[rob_addr]    <= req_reg.flag_valid;
                rob_tag_reg[rob_addr]      <= req_reg.has_rename ?
                                              {1'b1, req_reg.ren_tag} : 5'd0;
            end
            if (cmd.finish)
            begin
                complete_done_reg <= 1'b1;
            end
            // The head advances at once unless a rename update follows.
            if (cmd.retire)
            begin
                rob_busy_reg[head_reg] <= 1'b0;
                if (!head_tag_ok)
                begin
                    head_reg <= head_inc;
                end
            end
            if (cmd.rename_update)
            begin
                head_reg <= head_inc;
            end
        end
    end

    // Rename file memory: written by requests, read once per retiring entry.
    always_ff @(posedge clk)
    begin
        if (cmd.table_write && (req_reg.op == rbr_pkg::OP_RRF_WR) && rrf_in_range)
        begin
            rrf_data_mem[rrf_addr] <= DATA_WIDTH'(req_reg.data_value);
            rrf_dest_mem[rrf_addr] <= req_reg.dest_reg;
        end
        if (cmd.retire)
        begin
            rrf_data_q_reg <= rrf_data_mem[head_rrf_addr];
            rrf_dest_q_reg <= rrf_dest_mem[head_rrf_addr];
            ret_tag_reg    <= head_tag[3:0];
        end
    end

    // Architectural data memory: written on rename update, read by read requests.
    always_ff @(posedge clk)
    begin
        if (cmd.rename_update && ren_dest_ok)
        begin
            arf_data_mem[ren_dest_addr] <= rrf_data_q_reg;
        end
        if (cmd.arf_read)
        begin
            arf_rd_q_reg <= arf_data_mem[dest_addr];
        end
    end

    // Architectural valid bits, tags and busy bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arf_valid_reg    <= '0;
            arf_busy_reg     <= '0;
            for (int i = 0; i < ARF_DEPTH; i++)
            begin
                arf_tag_reg[i] <= '0;
            end
            arf_rd_valid_reg <= 1'b0;
            arf_rd_busy_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.table_write && (req_reg.op == rbr_pkg::OP_ARF_MAP) && dest_in_range)
            begin
                arf_tag_reg[dest_addr]  <= req_reg.ren_tag;
                arf_busy_reg[dest_addr] <= req_reg.flag_busy;
            end
            if (cmd.rename_update && ren_dest_ok)
            begin
                arf_valid_reg[ren_dest_addr] <= 1'b1;
                if (arf_tag_reg[ren_dest_addr] == ret_tag_reg)
                begin
                    arf_busy_reg[ren_dest_addr] <= 1'b0;
                end
            end
            if (cmd.arf_read)
            begin
                arf_rd_valid_reg <= arf_valid_reg[dest_addr];
                arf_rd_busy_reg  <= arf_busy_reg[dest_addr];
            end
        end
    end

    // Retire counter for the current commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (cmd.retire)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Result register; the strobe is the emit command, registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.retired_count    <= 5'(count_reg);
            rsp_reg.stage_done       <= complete_done_reg | cmd.finish;
            rsp_reg.buffer_was_empty <= cmd.finish & ~(|rob_busy_reg);
            rsp_reg.read_data        <= (cmd.read_out && dest_in_range && arf_rd_valid_reg) ?
                                        32'(arf_rd_q_reg) : 32'd0;
            rsp_reg.read_busy        <= cmd.read_out & dest_in_range & arf_rd_busy_reg;
            rsp_reg.head_index       <= 4'(head_reg);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- bench/rob_retire_checker.sv -----
`timescale 1ns / 100ps

// Watches the request and result channels of the retire stage, keeps shadow
// copies of the reorder buffer, rename file and architectural file, and checks
// every result against the shadow's prediction.
module rob_retire_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  rbr_pkg::req_t req,
    input  logic          done,
    input  rbr_pkg::rsp_t rsp,
    output int            fail_count,
    output int            outstanding,
    output int            retired_total
);

    localparam int ROB_N = rbr_pkg::ROB_DEPTH_DEF;
    localparam int RRF_N = rbr_pkg::RRF_DEPTH_DEF;
    localparam int ARF_N = rbr_pkg::ARF_DEPTH_DEF;

    // Shadow reorder buffer: bit 4 of the tag marks an entry with a rename.
    bit [ROB_N-1:0] rob_busy;
    bit [ROB_N-1:0] rob_finished;
    bit [ROB_N-1:0] rob_valid;
    logic [4:0]     rob_tag [ROB_N];

    // Shadow rename file.
    logic [31:0]    rrf_data [RRF_N];
    logic [4:0]     rrf_dest [RRF_N];
    bit [RRF_N-1:0] rrf_busy;

    // Shadow architectural file.
    logic [31:0]    arf_data [ARF_N];
    logic [3:0]     arf_tag [ARF_N];
    bit [ARF_N-1:0] arf_busy;

    logic [3:0]     head;
    bit             stage_finished;

    rbr_pkg::rsp_t  rsp_due [$];
    rbr_pkg::rsp_t  want;
    int             mismatches;
    int             results_seen;
    int             retired_sum;

    assign fail_count    = mismatches;
    assign retired_total = retired_sum;

    // Prints one line per discrepancy and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
    endtask

    // Applies one request to the shadow tables and returns the result it causes.
    function automatic rbr_pkg::rsp_t step_shadow(input rbr_pkg::req_t r);
        rbr_pkg::rsp_t o;
        logic [3:0]    t;
        logic [4:0]    d;
        bit            stop;
        o = '0;
        case (r.op)
            rbr_pkg::OP_ROB_WR:
            begin
                rob_busy[r.rob_index]     = r.flag_busy;
                rob_finished[r.rob_index] = r.flag_finished;
                rob_valid[r.rob_index]    = r.flag_valid;
                rob_tag[r.rob_index]      = r.has_rename ? {1'b1, r.ren_tag} : 5'd0;
            end
            rbr_pkg::OP_RRF_WR:
            begin
                rrf_data[r.rrf_index] = r.data_value;
                rrf_dest[r.rrf_index] = r.dest_reg;
                rrf_busy[r.rrf_index] = r.flag_busy;
            end
            rbr_pkg::OP_ARF_MAP:
            begin
                arf_tag[r.dest_reg]  = r.ren_tag;
                arf_busy[r.dest_reg] = r.flag_busy;
            end
            rbr_pkg::OP_COMMIT:
            begin
                if (!stage_finished)
                begin
                    if (r.execute_finished)
                    begin
                        // Finishing commit: report whether any entry was still busy.
                        o.buffer_was_empty = (rob_busy == '0);
                        stage_finished = 1'b1;
                    end
                    else
                    begin
                        // Retire in order from the head, at most one full lap.
                        stop = 1'b0;
                        for (int n = 0; n < ROB_N; n++)
                        begin
                            if (!stop && rob_busy[head] && rob_finished[head]
                                && rob_valid[head])
                            begin
                                rob_busy[head] = 1'b0;
                                if (rob_tag[head][4])
                                begin
                                    t = rob_tag[head][3:0];
                                    d = rrf_dest[t];
                                    rrf_busy[t] = 1'b0;
                                    arf_data[d] = rrf_data[t];
                                    if (arf_tag[d] == t)
                                        arf_busy[d] = 1'b0;
                                end
                                o.retired_count = o.retired_count + 1'b1;
                                retired_sum++;
                                head = head + 1'b1;
                            end
                            else
                                stop = 1'b1;
                        end
                    end
                end
            end
            rbr_pkg::OP_ARF_RD:
            begin
                o.read_data = arf_data[r.dest_reg];
                o.read_busy = arf_busy[r.dest_reg];
            end
            default:
            begin
            end
        endcase
        o.stage_done = stage_finished;
        o.head_index = head;
        return o;
    endfunction

    // Compare each result with the oldest prediction, then predict the new transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rob_busy       = '0;
            rob_finished   = '0;
            rob_valid      = '0;
            rrf_busy       = '0;
            arf_busy       = '0;
            head           = '0;
            stage_finished = 1'b0;
            for (int i = 0; i < ROB_N; i++)
                rob_tag[i] = '0;
            for (int i = 0; i < RRF_N; i++)
            begin
                rrf_data[i] = '0;
                rrf_dest[i] = '0;
            end
            for (int i = 0; i < ARF_N; i++)
            begin
                arf_data[i] = '0;
                arf_tag[i]  = '0;
            end
            rsp_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (rsp_due.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("retired_count", 32'(rsp.retired_count),
                                32'(want.retired_count));
                    check_field("stage_done", 32'(rsp.stage_done), 32'(want.stage_done));
                    check_field("buffer_was_empty", 32'(rsp.buffer_was_empty),
                                32'(want.buffer_was_empty));
                    check_field("read_data", rsp.read_data, want.read_data);
                    check_field("read_busy", 32'(rsp.read_busy), 32'(want.read_busy));
                    check_field("head_index", 32'(rsp.head_index), 32'(want.head_index));
                end
                results_seen++;
            end
            if (start && !busy)
                rsp_due.push_back(step_shadow(req));
            outstanding <= rsp_due.size();
        end
    end

endmodule

// ----- bench/reorder_buffer_retire_top_test.sv -----
`timescale 1ns / 100ps

module reorder_buffer_retire_top_test;

    localparam int HALF_PERIOD = 5;
    localparam int ITEM_TARGET = 1200;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    // Codes the block has no meaning for.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    rbr_pkg::req_t req;
    logic          done;
    rbr_pkg::rsp_t rsp;

    int         fail_count;
    int         outstanding;
    int         retired_total;
    int         idle_pct;
    int         sent;
    int         quiet;
    int         bursts;
    bit [15:0]  rrf_written;
    bit         finish_allowed;
    bit         paused;
    bit         cleared_first;
    logic [3:0] seen_head;

    always #HALF_PERIOD clk = ~clk;

    reorder_buffer_retire_top u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    rob_retire_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .retired_total (retired_total)
    );

    // Latest head reported by the block, used only to aim the buffer fills.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_head <= '0;
        else if (done)
            seen_head <= rsp.head_index;
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((start && !busy) || done)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Every field random; callers override what they care about.
    function automatic rbr_pkg::req_t rand_req();
        rbr_pkg::req_t r;
        r.op               = 3'($urandom_range(0, 7));
        r.rob_index        = 4'($urandom_range(0, 15));
        r.ren_tag          = 4'($urandom_range(0, 15));
        r.has_rename       = 1'($urandom_range(0, 1));
        r.flag_busy        = 1'($urandom_range(0, 1));
        r.flag_finished    = 1'($urandom_range(0, 1));
        r.flag_valid       = 1'($urandom_range(0, 1));
        r.rrf_index        = 4'($urandom_range(0, 15));
        r.dest_reg         = 5'($urandom_range(0, 31));
        r.data_value       = $urandom;
        r.execute_finished = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // One transfer on the request channel, after any idle cycles of this phase.
    // A rename tag is only attached once that rename entry has been written, and
    // the finishing commit is held back until the closing phase.
    task automatic send(input rbr_pkg::req_t r);
        if (r.op == rbr_pkg::OP_COMMIT && !finish_allowed)
            r.execute_finished = 1'b0;
        if (r.op == rbr_pkg::OP_ROB_WR && r.has_rename && !rrf_written[r.ren_tag])
            r.has_rename = 1'b0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.op == rbr_pkg::OP_RRF_WR)
            rrf_written[r.rrf_index] = 1'b1;
        if (r.op <= rbr_pkg::OP_ARF_RD)
            sent++;
    endtask

    task automatic write_rob(input logic [3:0] idx, input logic [3:0] tag, input logic has,
                             input logic b, input logic f, input logic v);
        rbr_pkg::req_t r;
        r = rand_req();
        r.op            = rbr_pkg::OP_ROB_WR;
        r.rob_index     = idx;
        r.ren_tag       = tag;
        r.has_rename    = has;
        r.flag_busy     = b;
        r.flag_finished = f;
        r.flag_valid    = v;
        send(r);
    endtask

    task automatic write_rrf(input logic [3:0] idx, input logic [4:0] dest,
                             input logic [31:0] data, input logic b);
        rbr_pkg::req_t r;
        r = rand_req();
        r.op         = rbr_pkg::OP_RRF_WR;
        r.rrf_index  = idx;
        r.dest_reg   = dest;
        r.data_value = data;
        r.flag_busy  = b;
        send(r);
    endtask

    task automatic map_arf(input logic [4:0] dest, input logic [3:0] tag, input logic b);
        rbr_pkg::req_t r;
        r = rand_req();
        r.op         = rbr_pkg::OP_ARF_MAP;
        r.dest_reg   = dest;
        r.ren_tag    = tag;
        r.flag_busy  = b;
        send(r);
    endtask

    task automatic read_arf(input logic [4:0] dest);
        rbr_pkg::req_t r;
        r = rand_req();
        r.op       = rbr_pkg::OP_ARF_RD;
        r.dest_reg = dest;
        send(r);
    endtask

    task automatic commit(input logic exec_done);
        rbr_pkg::req_t r;
        r = rand_req();
        r.op               = rbr_pkg::OP_COMMIT;
        r.execute_finished = exec_done;
        send(r);
    endtask

    // Stops sending and waits until every result owed has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // A well-formed fill of n entries from the head followed by a commit. When
    // spoilt, one entry loses a flag so the walk stops part-way.
    task automatic retire_burst(input int n, input bit spoilt);
        logic [3:0] tags [16];
        logic [4:0] dests [16];
        logic [3:0] base;
        int         bad;
        int         which;
        logic       b;
        logic       f;
        logic       v;
        read_arf(5'($urandom_range(0, 31)));
        for (int k = 0; k < n; k++)
        begin
            tags[k]  = 4'($urandom_range(0, 15));
            dests[k] = 5'($urandom_range(0, 31));
            write_rrf(tags[k], dests[k], $urandom, $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) != 0)
                map_arf(dests[k], ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                              : tags[k],
                        $urandom_range(0, 7) != 0);
        end
        base  = seen_head;
        bad   = spoilt ? $urandom_range(0, n - 1) : -1;
        which = $urandom_range(0, 2);
        for (int k = 0; k < n; k++)
        begin
            b = !(k == bad && which == 0);
            f = !(k == bad && which == 1);
            v = !(k == bad && which == 2);
            write_rob(base + 4'(k), tags[k], $urandom_range(0, 4) != 0, b, f, v);
        end
        commit(1'b0);
        read_arf(dests[$urandom_range(0, n - 1)]);
        bursts++;
    endtask

    initial
    begin
        rbr_pkg::req_t r;
        int            n;
        int            pick;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        req            <= '0;
        idle_pct       = 0;
        sent           = 0;
        bursts         = 0;
        rrf_written    = '0;
        finish_allowed = 1'b0;
        paused         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reads and a commit on the freshly reset tables.
        read_arf(5'd31);
        read_arf(5'd0);
        commit(1'b0);
        // Rename entries at the index and data extremes, and their mappings;
        // register 0 is mapped to another tag so its busy bit must survive.
        write_rrf(4'd15, 5'd31, 32'hFFFF_FFFF, 1'b1);
        write_rrf(4'd0, 5'd0, 32'h0000_0000, 1'b1);
        write_rrf(4'd7, 5'd17, 32'hA5A5_5A5A, 1'b0);
        map_arf(5'd31, 4'd15, 1'b1);
        map_arf(5'd0, 4'd3, 1'b1);
        map_arf(5'd17, 4'd7, 1'b1);
        // Three ready entries, then one waiting on an unresolved branch.
        write_rob(4'd0, 4'd15, 1'b1, 1'b1, 1'b1, 1'b1);
        write_rob(4'd1, 4'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        write_rob(4'd2, 4'd0, 1'b0, 1'b1, 1'b1, 1'b1);
        write_rob(4'd3, 4'd7, 1'b1, 1'b1, 1'b1, 1'b0);
        commit(1'b0);
        read_arf(5'd31);
        read_arf(5'd0);
        // Branch resolved but not yet finished, then finished.
        write_rob(4'd3, 4'd7, 1'b1, 1'b1, 1'b0, 1'b1);
        commit(1'b0);
        write_rob(4'd3, 4'd7, 1'b1, 1'b1, 1'b1, 1'b1);
        commit(1'b0);
        read_arf(5'd17);
        // Unused codes with every other bit set.
        r = '1;
        r.op = OP_SPARE_A;
        send(r);
        r.op = OP_SPARE_B;
        send(r);
        r.op = OP_SPARE_C;
        send(r);

        // Random part: mostly well-formed fills, some spoilt ones, some noise.
        while (sent < ITEM_TARGET)
        begin
            case ((sent / 100) % 3)
                0: idle_pct = 0;
                1: idle_pct = 70;
                default: idle_pct = 24;
            endcase
            if (!paused && sent >= ITEM_TARGET / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            n = ($urandom_range(0, 19) == 0) ? 16 : $urandom_range(1, 6);
            if (pick <= 6)
                retire_burst(n, 1'b0);
            else if (pick == 7)
                retire_burst(n, 1'b1);
            else
                repeat ($urandom_range(1, 4)) send(rand_req());
        end

        // Closing phase: the finishing commit, with the buffer cleared first or
        // left holding whatever the random part put there, then more traffic.
        wait_drained();
        finish_allowed = 1'b1;
        cleared_first  = 1'($urandom_range(0, 1));
        if (cleared_first)
            for (int i = 0; i < 16; i++)
                write_rob(4'(i), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        commit(1'b1);
        repeat (12) send(rand_req());
        commit(1'($urandom_range(0, 1)));

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d requests and %0d fill-and-commit bursts, retiring %0d entries.",
                 sent, bursts, retired_total);
        $display("The finishing commit found the buffer %s.",
                 cleared_first ? "cleared beforehand" : "as the random traffic left it");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- reorder_buffer_retire_top.f -----
rtl/rbr_pkg.sv
rtl/rbr_ctrl.sv
rtl/rbr_datapath.sv
rtl/reorder_buffer_retire_top.sv
bench/rob_retire_checker.sv
bench/reorder_buffer_retire_top_test.sv
